// ===== rtl/stable_sorted_priority_queue_defines.svh =====
// Assertion macros used by the checker file
`ifndef STABLE_SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define SSPQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define SSPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sspq_pkg.sv =====
`timescale 1ns / 1ps
package sspq_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Operation codes carried in the request mode bit
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam int unsigned PRIO_FIELD_W  = 8;
  localparam int unsigned DATA_FIELD_W  = 16;
  localparam int unsigned COUNT_FIELD_W = 5;

  // Request beat
  typedef struct packed {
    logic                    mode;
    logic [PRIO_FIELD_W-1:0] priority_req;
    logic [DATA_FIELD_W-1:0] client_id;
  } req_t;

  // Result beat
  typedef struct packed {
    status_e                  status;
    logic [PRIO_FIELD_W-1:0]  out_priority;
    logic [DATA_FIELD_W-1:0]  out_client_id;
    logic [COUNT_FIELD_W-1:0] fill_count;
  } res_t;

  // Operation broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

// ===== rtl/sspq_cell.sv =====
`timescale 1ns / 1ps
module sspq_cell #(
  parameter int unsigned PRIO_W = 8,
  parameter int unsigned DATA_W = 16,
  parameter int unsigned CNT_W  = 5,
  parameter int unsigned INDEX  = 0
) (
  input  logic                clk_i,
  input  sspq_pkg::cell_ctl_t ctl_i,
  input  logic [CNT_W-1:0]    count_i,
  input  logic [PRIO_W-1:0]   new_prio_i,
  input  logic [DATA_W-1:0]   new_data_i,
  input  logic                left_keep_i,
  input  logic [PRIO_W-1:0]   left_prio_i,
  input  logic [DATA_W-1:0]   left_data_i,
  input  logic [PRIO_W-1:0]   right_prio_i,
  input  logic [DATA_W-1:0]   right_data_i,
  output logic                keep_o,
  output logic [PRIO_W-1:0]   prio_o,
  output logic [DATA_W-1:0]   data_o
);
  import sspq_pkg::*;

  localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

  logic              valid;
  logic [PRIO_W-1:0] prio_q, prio_d;
  logic [DATA_W-1:0] data_q, data_d;

  // Occupancy follows from the fill count; entries below it are sorted
  assign valid  = (IDX < count_i);
  // An entry of equal or lower number stays ahead of the new one
  assign keep_o = valid && (prio_q <= new_prio_i);

  // Hold, take the new entry, shift right on insert, shift left on remove
  always_comb begin
    prio_d = prio_q;
    data_d = data_q;
    if (ctl_i.ins && !keep_o) begin
      if (left_keep_i) begin
        prio_d = new_prio_i;
        data_d = new_data_i;
      end else begin
        prio_d = left_prio_i;
        data_d = left_data_i;
      end
    end else if (ctl_i.rem) begin
      prio_d = right_prio_i;
      data_d = right_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    data_q <= data_d;
  end

  assign prio_o = prio_q;
  assign data_o = data_q;

endmodule

// ===== rtl/stable_sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// Stable min-first priority queue built as a row of sorted storage cells.
// Request channel: req_i is taken at a clock edge where start is high and
// busy is low. mode 0 inserts (priority_req, client_id); mode 1 removes the
// entry with the smallest priority number. Equal priorities leave in the
// order they arrived.
// Result channel: every request beat gives exactly one result beat on res_o,
// marked by done_o for one cycle, on the cycle after the request edge.
// busy stays low, so one request is taken every cycle.
// The throughput of one beat per cycle is set by the cell row: each cell
// compares the new priority against its own entry and shifts in the same
// cycle, so no search or shift loop spans cycles.
// Insert into a full queue reports ST_FULL and leaves the queue as it was;
// remove from an empty queue reports ST_EMPTY. fill_count gives the number
// held after the operation.
// Reset empties the queue at once (the fill count is cleared; cell contents
// need no clearing). The receiver cannot stall: results must be taken in the
// cycle done_o is high.
module stable_sorted_priority_queue #(
  parameter int unsigned CAPACITY      = 16,
  parameter int unsigned PRIORITY_BITS = 8,
  parameter int unsigned PAYLOAD_BITS  = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  sspq_pkg::req_t req_i,
  output logic           done_o,
  output sspq_pkg::res_t res_o
);
  import sspq_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [CNT_W-1:0] count_q, count_d;
  logic             accept, full, empty;
  cell_ctl_t        ctl;
  logic [PRIORITY_BITS-1:0] new_prio;
  logic [PAYLOAD_BITS-1:0]  new_data;

  logic [PRIORITY_BITS+PRIO_FIELD_W-1:0] prio_in_ext;
  logic [PAYLOAD_BITS+DATA_FIELD_W-1:0]  data_in_ext;
  logic [PRIORITY_BITS+PRIO_FIELD_W-1:0] prio_out_ext;
  logic [PAYLOAD_BITS+DATA_FIELD_W-1:0]  data_out_ext;
  logic [CNT_W+COUNT_FIELD_W-1:0]        count_ext;

  logic [CAPACITY-1:0]      keep;
  logic [PRIORITY_BITS-1:0] cell_prio [CAPACITY];
  logic [PAYLOAD_BITS-1:0]  cell_data [CAPACITY];

  logic done_q;
  res_t res_q, res_d;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CAP_CNT);
  assign empty  = (count_q == '0);

  // Operation decode
  assign ctl.ins = accept && (req_i.mode == MODE_INSERT) && !full;
  assign ctl.rem = accept && (req_i.mode == MODE_REMOVE) && !empty;

  // Fit request fields to the stored widths
  assign prio_in_ext = {{PRIORITY_BITS{1'b0}}, req_i.priority_req};
  assign data_in_ext = {{PAYLOAD_BITS{1'b0}}, req_i.client_id};
  assign new_prio    = prio_in_ext[PRIORITY_BITS-1:0];
  assign new_data    = data_in_ext[PAYLOAD_BITS-1:0];

  // Cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     left_keep;
    logic [PRIORITY_BITS-1:0] left_prio, right_prio;
    logic [PAYLOAD_BITS-1:0]  left_data, right_data;

    if (i == 0) begin : g_first
      assign left_keep = 1'b1;
      assign left_prio = new_prio;
      assign left_data = new_data;
    end else begin : g_inner
      assign left_keep = keep[i-1];
      assign left_prio = cell_prio[i-1];
      assign left_data = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_prio = '0;
      assign right_data = '0;
    end else begin : g_mid
      assign right_prio = cell_prio[i+1];
      assign right_data = cell_data[i+1];
    end

    sspq_cell #(
      .PRIO_W (PRIORITY_BITS),
      .DATA_W (PAYLOAD_BITS),
      .CNT_W  (CNT_W),
      .INDEX  (i)
    ) u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .count_i      (count_q),
      .new_prio_i   (new_prio),
      .new_data_i   (new_data),
      .left_keep_i  (left_keep),
      .left_prio_i  (left_prio),
      .left_data_i  (left_data),
      .right_prio_i (right_prio),
      .right_data_i (right_data),
      .keep_o       (keep[i]),
      .prio_o       (cell_prio[i]),
      .data_o       (cell_data[i])
    );
  end

  // Fill count
  always_comb begin
    count_d = count_q;
    if (ctl.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctl.rem) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // Result beat
  assign prio_out_ext = {{PRIO_FIELD_W{1'b0}}, cell_prio[0]};
  assign data_out_ext = {{DATA_FIELD_W{1'b0}}, cell_data[0]};
  assign count_ext    = {{COUNT_FIELD_W{1'b0}}, count_d};

  always_comb begin
    res_d               = '0;
    res_d.fill_count    = count_ext[COUNT_FIELD_W-1:0];
    res_d.status        = ST_OK;
    if (req_i.mode == MODE_INSERT) begin
      if (full) begin
        res_d.status = ST_FULL;
      end
    end else if (empty) begin
      res_d.status = ST_EMPTY;
    end else begin
      res_d.out_priority  = prio_out_ext[PRIO_FIELD_W-1:0];
      res_d.out_client_id = data_out_ext[DATA_FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== rtl/sspq_checker.sv =====
`timescale 1ns / 1ps
`include "stable_sorted_priority_queue_defines.svh"
module sspq_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_i,
  input sspq_pkg::res_t res_i
);
  import sspq_pkg::*;

  localparam int unsigned EXT_W = COUNT_FIELD_W + 32;
  localparam logic [EXT_W-1:0] CAP_EXT = EXT_W'(CAPACITY);
  localparam logic [COUNT_FIELD_W-1:0] CAP_FIELD = CAP_EXT[COUNT_FIELD_W-1:0];

  logic beat;
  logic empty_seen, empty_clean;
  logic full_seen, full_clean;

  assign beat = start && !busy;

  // Status decode of the result beat
  assign empty_seen  = done_i && (res_i.status == ST_EMPTY);
  assign empty_clean = (res_i.fill_count == '0) && (res_i.out_priority == '0);
  assign full_seen   = done_i && (res_i.status == ST_FULL);
  assign full_clean  = (res_i.fill_count == CAP_FIELD) && (res_i.out_client_id == '0);

  // Every request beat gives one result beat on the next cycle
  `SSPQ_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, beat, done_i, "result beat missing")

  // No result without a request beat
  `SSPQ_ASSERT_NEXT(a_no_spurious, clk_i, rst_ni, !beat, !done_i, "unexpected result beat")

  // Empty report only when nothing is held
  `SSPQ_ASSERT_NOW(a_empty_count, clk_i, rst_ni, empty_seen, empty_clean, "bad empty beat")

  // Full report only at capacity, with no entry returned
  `SSPQ_ASSERT_NOW(a_full_count, clk_i, rst_ni, full_seen, full_clean, "bad full beat")

endmodule

bind stable_sorted_priority_queue sspq_checker #(
  .CAPACITY (CAPACITY)
) u_sspq_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_i (done_o),
  .res_i  (res_o)
);
